### rtl/ntc_pkg.sv
package ntc_pkg;

    localparam int ROM_SIZE   = 117;
    localparam int ROM_IDX_W  = 7;
    localparam int RES_W      = 16;
    localparam int DIVIDEND_W = 30;
    localparam int DIVISOR_W  = 16;
    localparam int STEPS_W    = 5;
    localparam int FRAC_NUM_W = 14;
    localparam int TEMP_W     = 11;

    localparam logic [13:0]          RES_SCALE   = 14'd10000;
    localparam logic [STEPS_W-1:0]   RES_STEPS   = 5'd30;
    localparam logic [STEPS_W-1:0]   FRAC_STEPS  = 5'd14;
    localparam logic [TEMP_W-1:0]    TEMP_OFFSET = 11'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV_RES,
        ST_RANGE,
        ST_SEARCH,
        ST_FRAC,
        ST_DIV_FRAC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [STEPS_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Thermistor resistance in ohms, one entry per degree, falling.
    localparam logic [RES_W-1:0] RES_ROM [ROM_SIZE] = '{
        16'd20700, 16'd19788, 16'd18838, 16'd17977, 16'd17160, 16'd16383, 16'd15646,
        16'd14945, 16'd14280, 16'd13647, 16'd13045, 16'd12472, 16'd11928, 16'd11409,
        16'd10916, 16'd10447, 16'd10000, 16'd9574,  16'd9168,  16'd8781,  16'd8413,
        16'd8062,  16'd7727,  16'd7407,  16'd7103,  16'd6812,  16'd6534,  16'd6270,
        16'd6017,  16'd5775,  16'd5545,  16'd5324,  16'd5114,  16'd4913,  16'd4720,
        16'd4536,  16'd4360,  16'd4192,  16'd4031,  16'd3877,  16'd3730,  16'd3572,
        16'd3454,  16'd3324,  16'd3201,  16'd3082,  16'd2968,  16'd2859,  16'd2755,
        16'd2654,  16'd2558,  16'd2466,  16'd2378,  16'd2293,  16'd2212,  16'd2134,
        16'd2059,  16'd1987,  16'd1918,  16'd1851,  16'd1788,  16'd1726,  16'd1668,
        16'd1611,  16'd1557,  16'd1504,  16'd1454,  16'd1406,  16'd1359,  16'd1314,
        16'd1271,  16'd1230,  16'd1190,  16'd1151,  16'd1114,  16'd1079,  16'd1045,
        16'd1011,  16'd980,   16'd949,   16'd919,   16'd891,   16'd863,   16'd837,
        16'd811,   16'd786,   16'd763,   16'd740,   16'd718,   16'd696,   16'd675,
        16'd656,   16'd636,   16'd618,   16'd600,   16'd582,   16'd566,   16'd549,
        16'd534,   16'd519,   16'd504,   16'd490,   16'd476,   16'd463,   16'd450,
        16'd438,   16'd426,   16'd414,   16'd403,   16'd392,   16'd381,   16'd371,
        16'd361,   16'd352,   16'd342,   16'd333,   16'd325
    };

    function automatic logic [RES_W-1:0] res_entry(input logic [ROM_IDX_W-1:0] idx);
        logic [RES_W-1:0] val;
        val = '0;
        if (int'(idx) < ROM_SIZE)
        begin
            val = RES_ROM[idx];
        end
        return val;
    endfunction

endpackage

### rtl/ntc_adc_to_temperature.sv
// NTC thermistor ADC sample to temperature.
//
// Input stream s_axis_*: one request carries one 16-bit ADC sample of the
// thermistor divider. Output stream m_axis_*: one result per request, the
// temperature in tenths of a degree (tdata) and an in-range flag (tuser).
// Out-of-range resistance, or a sample at or above full scale, gives
// in_range = 0 and temperature 0. Config channel cfg_*: write the ADC
// full-scale count; it is always ready and is meant to be written idle.
//
// The shared serial divider sets the pace of an in-range sample: 30 steps
// for the resistance, 14 steps for the tenths digit, plus 7 table probes of
// the binary search. A sample at or above full scale skips both divides; a
// resistance off the table ends after the resistance divide and the range
// check. s_axis_tready is high only while the sequencer idles, so a new
// sample is taken only once the last one has left the sequencer.
// The result sits in an output register; a new sample is taken while it
// waits, but the next result holds in the sequencer until the receiver
// takes the first. Reset clears the sequencer and the output valid and
// loads full scale with 4096.
module ntc_adc_to_temperature #(
    parameter int TABLE_ENTRIES = 117
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] adc_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [10:0] temperature_tenths, [15:11] zero
    output logic [0:0]  m_axis_tuser,   // [0] in_range
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data        // adc_full_scale
);

    // Last usable table index, limited by the stored table.
    localparam int LAST_IDX = (TABLE_ENTRIES - 1 < ntc_pkg::ROM_SIZE - 1)
                              ? (TABLE_ENTRIES - 1) : (ntc_pkg::ROM_SIZE - 1);
    // The interpolation head ranges over 0 .. LAST_IDX-1.
    localparam int SEARCH_W = (LAST_IDX > 1) ? $clog2(LAST_IDX) : 1;
    localparam logic [SEARCH_W:0]   HEAD_MAX = (SEARCH_W + 1)'(LAST_IDX - 1);
    localparam logic [SEARCH_W-1:0] MASK_TOP = SEARCH_W'(1) << (SEARCH_W - 1);
    localparam logic [ntc_pkg::RES_W-1:0] RES_FIRST = ntc_pkg::RES_ROM[0];
    localparam logic [ntc_pkg::RES_W-1:0] RES_LAST  = ntc_pkg::RES_ROM[LAST_IDX];

    ntc_pkg::state_t state_reg, state_next;

    logic [15:0]                       fs_reg;
    logic [ntc_pkg::DIVIDEND_W-1:0]    product_reg;
    logic [ntc_pkg::DIVISOR_W-1:0]     span_reg;
    logic                              bad_reg;
    logic [ntc_pkg::DIVIDEND_W-1:0]    res_reg;
    logic [SEARCH_W-1:0]               head_reg;
    logic [SEARCH_W-1:0]               mask_reg;
    logic [ntc_pkg::TEMP_W-1:0]        temp_reg;
    logic                              ok_reg;
    logic                              m_valid_reg;
    logic [ntc_pkg::TEMP_W-1:0]        m_temp_reg;
    logic                              m_ok_reg;

    logic                              in_accept;
    logic                              out_load;
    logic                              range_bad;
    logic [SEARCH_W-1:0]               cand;
    logic                              probe_hit;
    logic [ntc_pkg::RES_W-1:0]         hi_res;
    logic [ntc_pkg::RES_W-1:0]         lo_res;
    logic [ntc_pkg::RES_W-1:0]         hi_minus_r;
    logic [19:0]                       frac_prod;
    logic [ntc_pkg::TEMP_W-1:0]        head_base;
    logic [ntc_pkg::TEMP_W-1:0]        temp_base;
    logic [31:0]                       mult_full;

    ntc_pkg::div_req_t                 div_req;
    ntc_pkg::div_stat_t                div_stat;
    logic [ntc_pkg::DIVIDEND_W-1:0]    div_dividend;
    logic [ntc_pkg::DIVISOR_W-1:0]     div_divisor;
    logic [ntc_pkg::DIVIDEND_W-1:0]    div_quotient;

    ntc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // Datapath combinational terms
    assign mult_full = {16'd0, s_axis_tdata} * {18'd0, ntc_pkg::RES_SCALE};
    assign range_bad = (res_reg >= {14'd0, RES_FIRST}) || (res_reg <= {14'd0, RES_LAST});
    assign cand      = head_reg | mask_reg;
    assign probe_hit = ({1'b0, cand} <= HEAD_MAX) &&
                       (ntc_pkg::res_entry(ntc_pkg::ROM_IDX_W'(cand)) >=
                        res_reg[ntc_pkg::RES_W-1:0]);
    assign hi_res     = ntc_pkg::res_entry(ntc_pkg::ROM_IDX_W'(head_reg));
    assign lo_res     = ntc_pkg::res_entry(ntc_pkg::ROM_IDX_W'(head_reg) +
                                           ntc_pkg::ROM_IDX_W'(1));
    assign hi_minus_r = hi_res - res_reg[ntc_pkg::RES_W-1:0];
    // Times ten as 8x + 2x; the difference stays below one table step.
    assign frac_prod  = ({4'd0, hi_minus_r} << 3) + ({4'd0, hi_minus_r} << 1);
    assign head_base  = ntc_pkg::TEMP_W'(head_reg) + ntc_pkg::TEMP_OFFSET;
    assign temp_base  = (head_base << 3) + (head_base << 1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ntc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ntc_pkg::ST_START;
                end
            end
            ntc_pkg::ST_START:
            begin
                state_next = bad_reg ? ntc_pkg::ST_DONE : ntc_pkg::ST_DIV_RES;
            end
            ntc_pkg::ST_DIV_RES:
            begin
                if (div_stat.done)
                begin
                    state_next = ntc_pkg::ST_RANGE;
                end
            end
            ntc_pkg::ST_RANGE:
            begin
                state_next = range_bad ? ntc_pkg::ST_DONE : ntc_pkg::ST_SEARCH;
            end
            ntc_pkg::ST_SEARCH:
            begin
                if (mask_reg[0])
                begin
                    state_next = ntc_pkg::ST_FRAC;
                end
            end
            ntc_pkg::ST_FRAC:
            begin
                state_next = ntc_pkg::ST_DIV_FRAC;
            end
            ntc_pkg::ST_DIV_FRAC:
            begin
                if (div_stat.done)
                begin
                    state_next = ntc_pkg::ST_DONE;
                end
            end
            ntc_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ntc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ntc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.steps = ntc_pkg::RES_STEPS;
        div_dividend  = product_reg;
        div_divisor   = span_reg;
        unique case (state_reg)
            ntc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ntc_pkg::ST_START:
            begin
                div_req.start = !bad_reg;
            end
            ntc_pkg::ST_FRAC:
            begin
                // Left-align the small numerator so fewer steps suffice.
                div_req.start = 1'b1;
                div_req.steps = ntc_pkg::FRAC_STEPS;
                div_dividend  = {frac_prod[ntc_pkg::FRAC_NUM_W-1:0],
                                 {(ntc_pkg::DIVIDEND_W - ntc_pkg::FRAC_NUM_W){1'b0}}};
                div_divisor   = hi_res - lo_res;
            end
            ntc_pkg::ST_DONE:
            begin
                out_load = !m_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ntc_pkg::ST_IDLE;
            fs_reg      <= 16'd4096;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                fs_reg <= cfg_data;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            product_reg <= mult_full[ntc_pkg::DIVIDEND_W-1:0];
            span_reg    <= fs_reg - s_axis_tdata;
            bad_reg     <= s_axis_tdata >= fs_reg;
            temp_reg    <= '0;
            ok_reg      <= 1'b0;
        end
        if (state_reg == ntc_pkg::ST_DIV_RES && div_stat.done)
        begin
            res_reg <= div_quotient;
        end
        if (state_reg == ntc_pkg::ST_RANGE)
        begin
            head_reg <= '0;
            mask_reg <= MASK_TOP;
        end
        if (state_reg == ntc_pkg::ST_SEARCH)
        begin
            // Keep a probe bit when it stays within the head range and the entry there is at or above r.
            if (probe_hit)
            begin
                head_reg <= cand;
            end
            mask_reg <= mask_reg >> 1;
        end
        if (state_reg == ntc_pkg::ST_DIV_FRAC && div_stat.done)
        begin
            temp_reg <= temp_base + ntc_pkg::TEMP_W'(div_quotient[3:0]);
            ok_reg   <= 1'b1;
        end
        if (out_load)
        begin
            m_temp_reg <= temp_reg;
            m_ok_reg   <= ok_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = {{(16 - ntc_pkg::TEMP_W){1'b0}}, m_temp_reg};
    assign m_axis_tuser[0] = m_ok_reg;

    // Checks
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ntc_pkg::ST_DIV_RES ||
                           state_reg == ntc_pkg::ST_DIV_FRAC))
        else $error("divider finished outside a divide state");

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
        else $error("out-of-range result not zero");

    a_out_span: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (m_axis_tdata >= 16'd90 && m_axis_tdata <= 16'd1259))
        else $error("in-range temperature outside table span");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ntc_pkg::ST_START))
        else $error("accepted sample did not start the sequencer");

endmodule

### rtl/ntc_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// A short divide loads its dividend left-aligned and runs fewer steps.
module ntc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ntc_pkg::div_req_t                   req,
    input  logic [ntc_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [ntc_pkg::DIVISOR_W-1:0]       divisor,
    output ntc_pkg::div_stat_t                  stat,
    output logic [ntc_pkg::DIVIDEND_W-1:0]      quotient
);

    logic [ntc_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [ntc_pkg::DIVISOR_W-1:0]  dvs_reg;
    logic [ntc_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [ntc_pkg::STEPS_W-1:0]    cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [ntc_pkg::DIVISOR_W:0] trial;
    logic [ntc_pkg::DIVISOR_W:0] trial_diff;
    logic                        fits;

    assign trial      = {rem_reg, quo_reg[ntc_pkg::DIVIDEND_W-1]};
    assign fits       = trial >= {1'b0, dvs_reg};
    assign trial_diff = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = fits ? trial_diff[ntc_pkg::DIVISOR_W-1:0] : trial[ntc_pkg::DIVISOR_W-1:0];
        quo_next = {quo_reg[ntc_pkg::DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ntc_pkg::STEPS_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### verif/ntc_adc_to_temperature_test.sv
module ntc_adc_to_temperature_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Own copy of the thermistor table: ohms per degree, falling, first entry at 9 degrees.
    localparam int NTC_ENTRIES = 117;
    localparam int NTC_LAST    = NTC_ENTRIES - 1;
    localparam logic [15:0] THERMISTOR_OHMS [NTC_ENTRIES] = '{
        16'd20700, 16'd19788, 16'd18838, 16'd17977, 16'd17160, 16'd16383, 16'd15646,
        16'd14945, 16'd14280, 16'd13647, 16'd13045, 16'd12472, 16'd11928, 16'd11409,
        16'd10916, 16'd10447, 16'd10000, 16'd9574,  16'd9168,  16'd8781,  16'd8413,
        16'd8062,  16'd7727,  16'd7407,  16'd7103,  16'd6812,  16'd6534,  16'd6270,
        16'd6017,  16'd5775,  16'd5545,  16'd5324,  16'd5114,  16'd4913,  16'd4720,
        16'd4536,  16'd4360,  16'd4192,  16'd4031,  16'd3877,  16'd3730,  16'd3572,
        16'd3454,  16'd3324,  16'd3201,  16'd3082,  16'd2968,  16'd2859,  16'd2755,
        16'd2654,  16'd2558,  16'd2466,  16'd2378,  16'd2293,  16'd2212,  16'd2134,
        16'd2059,  16'd1987,  16'd1918,  16'd1851,  16'd1788,  16'd1726,  16'd1668,
        16'd1611,  16'd1557,  16'd1504,  16'd1454,  16'd1406,  16'd1359,  16'd1314,
        16'd1271,  16'd1230,  16'd1190,  16'd1151,  16'd1114,  16'd1079,  16'd1045,
        16'd1011,  16'd980,   16'd949,   16'd919,   16'd891,   16'd863,   16'd837,
        16'd811,   16'd786,   16'd763,   16'd740,   16'd718,   16'd696,   16'd675,
        16'd656,   16'd636,   16'd618,   16'd600,   16'd582,   16'd566,   16'd549,
        16'd534,   16'd519,   16'd504,   16'd490,   16'd476,   16'd463,   16'd450,
        16'd438,   16'd426,   16'd414,   16'd403,   16'd392,   16'd381,   16'd371,
        16'd361,   16'd352,   16'd342,   16'd333,   16'd325
    };

    localparam logic [15:0] RESET_FULL_SCALE = 16'd4096;
    localparam int MAX_IDLE        = 18;
    localparam int SETTLE_CYCLES   = 70;    // a little over the worst in-range latency
    localparam int HOLD_AT_RESULT  = 130;   // result count at which the receiver backs off
    localparam int HOLD_CYCLES     = 500;
    localparam int TAIL_CYCLES     = 80;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    typedef enum logic [1:0] {
        OP_SAMPLE,      // send one ADC sample
        OP_SCALE,       // write the full-scale register
        OP_DRAIN        // hold off until every result is back, then settle
    } request_op_t;

    typedef struct {
        request_op_t op;
        logic [15:0] value;
    } request_t;

    typedef struct packed {
        logic [ntc_pkg::TEMP_W-1:0] tenths;
        logic                       in_range;
    } reading_t;

    logic        clk = 1'b1;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] adc_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [10:0] temperature_tenths, [15:11] zero
    logic [0:0]  m_axis_tuser;          // [0] in_range
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;         // adc_full_scale

    request_t    requests_pending[$];
    reading_t    readings_due[$];
    logic [15:0] full_scale_model;
    int          mismatches = 0;

    ntc_adc_to_temperature dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Divider resistance in ohms at full precision; only meaningful below full scale.
    function automatic longint unsigned divider_ohms(input logic [15:0] sample,
                                                     input logic [15:0] full_scale);
        longint unsigned num;
        longint unsigned den;
        num = longint'(sample) * 64'd10000;
        den = longint'(full_scale) - longint'(sample);
        return num / den;
    endfunction

    // Temperature in tenths of a degree: locate the bracketing pair of table
    // entries, then interpolate the tenths digit by truncating division.
    function automatic reading_t predict_reading(input logic [15:0] sample,
                                                 input logic [15:0] full_scale);
        reading_t        rd;
        longint unsigned ohms;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned tenths;
        int              head;
        rd = '0;
        if (sample >= full_scale)
        begin
            return rd;
        end
        ohms = divider_ohms(sample, full_scale);
        if (ohms >= THERMISTOR_OHMS[0] || ohms <= THERMISTOR_OHMS[NTC_LAST])
        begin
            return rd;
        end
        head = 0;
        while (head + 1 < NTC_LAST && THERMISTOR_OHMS[head + 1] >= ohms)
        begin
            head++;
        end
        hi = THERMISTOR_OHMS[head];
        lo = THERMISTOR_OHMS[head + 1];
        tenths = longint'(head + 9) * 10;
        if (hi > lo)
        begin
            tenths += (64'd10 * (hi - ohms)) / (hi - lo);
        end
        rd.tenths = tenths[ntc_pkg::TEMP_W-1:0];
        rd.in_range = 1'b1;
        return rd;
    endfunction

    // Smallest sample whose resistance reaches the target (resistance rises with the sample).
    function automatic logic [15:0] sample_for_ohms(input logic [15:0] full_scale,
                                                    input longint unsigned target);
        int lo_s;
        int hi_s;
        int mid;
        lo_s = 0;
        hi_s = int'(full_scale) - 1;
        if (hi_s < 0)
        begin
            return 16'd0;
        end
        while (lo_s < hi_s)
        begin
            mid = (lo_s + hi_s) / 2;
            if (divider_ohms(mid[15:0], full_scale) >= target)
            begin
                hi_s = mid;
            end
            else
            begin
                lo_s = mid + 1;
            end
        end
        return lo_s[15:0];
    endfunction

    task automatic queue_request(input request_op_t op, input logic [15:0] value);
        request_t req;
        req.op = op;
        req.value = value;
        requests_pending.push_back(req);
    endtask

    // Queue a sample just below and at the point where the resistance reaches the target.
    task automatic queue_crossing(input logic [15:0] full_scale, input longint unsigned target);
        logic [15:0] s;
        s = sample_for_ohms(full_scale, target);
        queue_request(OP_SAMPLE, s - 16'd1);
        queue_request(OP_SAMPLE, s);
    endtask

    // Build the whole run up front. Each phase runs at one full-scale setting;
    // the first keeps the reset value, every later one drains and rewrites it.
    initial
    begin
        logic [15:0] scales[9];
        int          counts[9];
        logic [15:0] fs;
        int          lo_s;
        int          hi_s;
        int          pick;
        int          s;
        scales = '{RESET_FULL_SCALE, 16'hFFFF, 16'd1, 16'd0, 16'd1023,
                   16'($urandom_range(2, 65534)), 16'($urandom_range(100, 8000)),
                   16'($urandom_range(20000, 65534)), RESET_FULL_SCALE};
        counts = '{90, 90, 30, 30, 90, 90, 90, 90, 90};
        for (int ph = 0; ph < 9; ph++)
        begin
            fs = scales[ph];
            if (ph > 0)
            begin
                queue_request(OP_DRAIN, '0);
                queue_request(OP_SCALE, fs);
            end
            if (ph == 0)
            begin
                // zero, just under, at and far over full scale, alternating bits
                queue_request(OP_SAMPLE, 16'd0);
                queue_request(OP_SAMPLE, fs - 16'd1);
                queue_request(OP_SAMPLE, fs);
                queue_request(OP_SAMPLE, 16'hFFFF);
                queue_request(OP_SAMPLE, 16'h0555);
                queue_request(OP_SAMPLE, 16'h0AAA);
            end
            if (ph == 1)
            begin
                // Full 16-bit scale gives fine steps: hit both table ends and exact entries.
                queue_request(OP_SAMPLE, 16'd0);
                queue_request(OP_SAMPLE, 16'hFFFE);
                queue_request(OP_SAMPLE, 16'hFFFF);
                queue_request(OP_SAMPLE, 16'h5555);
                queue_request(OP_SAMPLE, 16'hAAAA);
                queue_crossing(fs, THERMISTOR_OHMS[0]);
                queue_crossing(fs, longint'(THERMISTOR_OHMS[NTC_LAST]) + 1);
                queue_crossing(fs, THERMISTOR_OHMS[1]);
                queue_crossing(fs, THERMISTOR_OHMS[16]);
                queue_crossing(fs, THERMISTOR_OHMS[58]);
                queue_crossing(fs, THERMISTOR_OHMS[NTC_LAST - 1]);
            end
            // Most samples land on the table, some near full scale, the rest anywhere.
            lo_s = int'(fs) * 315 / 10000;
            hi_s = int'(fs) * 675 / 1000;
            for (int n = 0; n < counts[ph]; n++)
            begin
                if (ph >= 4 && n == counts[ph] / 2)
                begin
                    queue_request(OP_DRAIN, '0);
                end
                pick = $urandom_range(0, 9);
                if (pick < 7 && hi_s > lo_s)
                begin
                    s = $urandom_range(hi_s, lo_s);
                end
                else if (pick == 7)
                begin
                    s = int'(fs) - int'($urandom_range(0, 2));
                end
                else
                begin
                    s = $urandom;
                end
                queue_request(OP_SAMPLE, s[15:0]);
            end
        end
    end

    // Sender: present one request at a time, with a random gap after each sample unless calm.
    int sender_gap;
    int settle_count;
    bit sender_calm;

    always @(posedge clk or negedge rst_n)
    begin
        logic     next_svalid;
        logic     next_cvalid;
        request_t head;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            cfg_valid <= 1'b0;
            cfg_data <= '0;
            full_scale_model = RESET_FULL_SCALE;
            sender_gap = 0;
            settle_count = 0;
            sender_calm = 1'b0;
        end
        else
        begin
            next_svalid = s_axis_tvalid;
            next_cvalid = cfg_valid;
            // Retire whatever was accepted at this edge and predict its result.
            if (s_axis_tvalid && s_axis_tready)
            begin
                readings_due.push_back(predict_reading(s_axis_tdata, full_scale_model));
                next_svalid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                full_scale_model = cfg_data;
                next_cvalid = 1'b0;
            end
            if (!next_svalid && !next_cvalid)
            begin
                if (sender_gap > 0)
                begin
                    sender_gap--;
                end
                else if (requests_pending.size() > 0)
                begin
                    head = requests_pending[0];
                    case (head.op)
                        OP_SAMPLE:
                        begin
                            s_axis_tdata <= head.value;
                            next_svalid = 1'b1;
                            void'(requests_pending.pop_front());
                            // Switch now and then between bursts and gappy traffic.
                            if ($urandom_range(0, 39) == 0)
                            begin
                                sender_calm = !sender_calm;
                            end
                            sender_gap = sender_calm ? 0 : $urandom_range(0, MAX_IDLE);
                        end
                        OP_SCALE:
                        begin
                            cfg_data <= head.value;
                            next_cvalid = 1'b1;
                            void'(requests_pending.pop_front());
                        end
                        OP_DRAIN:
                        begin
                            // Hold until every result is back, then let the block settle.
                            if (readings_due.size() != 0)
                            begin
                                settle_count = 0;
                            end
                            else if (settle_count >= SETTLE_CYCLES)
                            begin
                                settle_count = 0;
                                void'(requests_pending.pop_front());
                            end
                            else
                            begin
                                settle_count++;
                            end
                        end
                        default:
                        begin
                            void'(requests_pending.pop_front());
                        end
                    endcase
                end
            end
            s_axis_tvalid <= next_svalid;
            cfg_valid <= next_cvalid;
        end
    end

    // Receiver: check each result against the oldest prediction, stall at random,
    // and once hold off for a long stretch so the block backs up and stalls its input.
    int       results_taken;
    int       receiver_stall;
    int       hold_count;
    bit       hold_done;
    bit       receiver_calm;
    reading_t due;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            results_taken = 0;
            receiver_stall = 0;
            hold_count = 0;
            hold_done = 1'b0;
            receiver_calm = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_taken++;
                if (readings_due.size() == 0)
                begin
                    $display("%0t: result with none expected: tdata=%0d in_range=%0b",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                    mismatches++;
                end
                else
                begin
                    due = readings_due.pop_front();
                    if (m_axis_tdata[ntc_pkg::TEMP_W-1:0] !== due.tenths)
                    begin
                        $display("%0t: temperature_tenths expected %0d, got %0d",
                                 $time, due.tenths, m_axis_tdata[ntc_pkg::TEMP_W-1:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[15:ntc_pkg::TEMP_W] !== '0)
                    begin
                        $display("%0t: tdata padding expected 0, got %0h",
                                 $time, m_axis_tdata[15:ntc_pkg::TEMP_W]);
                        mismatches++;
                    end
                    if (m_axis_tuser[0] !== due.in_range)
                    begin
                        $display("%0t: in_range expected %0b, got %0b",
                                 $time, due.in_range, m_axis_tuser[0]);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    receiver_calm = !receiver_calm;
                end
                receiver_stall = receiver_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (results_taken == HOLD_AT_RESULT && !hold_done)
            begin
                hold_count = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                m_axis_tready <= 1'b0;
            end
            else if (receiver_stall > 0)
            begin
                receiver_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Reset once, wait for all requests and results, give the block a tail, report.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (requests_pending.size() != 0 || s_axis_tvalid || cfg_valid
               || readings_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && readings_due.size() == 0)
        begin
            $display("** ntc_adc_to_temperature: PASSED **");
        end
        else
        begin
            $display("** ntc_adc_to_temperature: FAILED **");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("%0t: run limit reached, %0d results outstanding", $time, readings_due.size());
        $display("** ntc_adc_to_temperature: FAILED **");
        $finish;
    end

endmodule
